// File: rtl/event_tof_histogrammer_defines.svh
// ----------------------------------------------------------------------------
// Event TOF histogrammer assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef EVENT_TOF_HISTOGRAMMER_DEFINES_SVH
`define EVENT_TOF_HISTOGRAMMER_DEFINES_SVH

// same-cycle implication
`define ETOF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ETOF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/etof_pkg.sv
// ----------------------------------------------------------------------------
// Event TOF histogrammer package
// Types, codes and widths shared by the histogrammer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package etof_pkg;

	localparam int unsigned DETECTORS_DEF = 256;
	localparam int unsigned BINS_DEF      = 1024;

	localparam int unsigned TIME_W    = 32;
	localparam int unsigned FRAME_W   = 48;
	localparam int unsigned IDX_W     = 11;
	localparam int unsigned DET_W     = 8;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned STAT_W    = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned QDEPTH    = 2;

	localparam logic [FRAME_W-1:0] WIN_END_RST = '1;
	localparam logic [IDX_W-1:0]   BINS_RST    = 11'd1024;

	typedef enum logic [1:0] {
		ACT_EDGE  = 2'd0,
		ACT_FRAME = 2'd1,
		ACT_EVENT = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE      = 2'd0,
		ST_IGNORED   = 2'd1,
		ST_DET_RANGE = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIN_START = 2'd0,
		CFG_WIN_END   = 2'd1,
		CFG_BINS      = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_DECODE,
		B_CHK0,
		B_CHKN,
		B_SRCH,
		B_CINC,
		B_CRD
	} back_state_t;

	// classified item as it sits in the queue
	typedef struct packed {
		action_t             action;
		logic [IDX_W-1:0]    bin_index;
		logic [DET_W-1:0]    det;
		logic [TIME_W-1:0]   tval;
		logic                in_window;
		logic                det_zero;
		logic                det_oob;
		logic                edge_oob;
		logic                bin_oob;
	} item_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

endpackage

`default_nettype wire

// File: rtl/etof_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module etof_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/etof_front.sv
// ----------------------------------------------------------------------------
// Histogrammer front end
// Accepts commands, classifies them against the window and ranges, queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module etof_front #(
	parameter int unsigned DETECTORS = etof_pkg::DETECTORS_DEF,
	parameter int unsigned BINS      = etof_pkg::BINS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   action,
	input  logic [etof_pkg::IDX_W-1:0]   bin_index,
	input  logic [etof_pkg::DET_W-1:0]   detector_id,
	input  logic [etof_pkg::TIME_W-1:0]  time_value,
	input  logic [etof_pkg::FRAME_W-1:0] frame_time,
	input  logic [etof_pkg::FRAME_W-1:0] window_start,
	input  logic [etof_pkg::FRAME_W-1:0] window_end,
	input  logic                         clearing,
	input  logic                         pop,
	output logic                         head_valid,
	output etof_pkg::item_t              head
);
	import etof_pkg::*;

	localparam int unsigned PW = $clog2(QDEPTH);

	item_t            new_item;
	item_t            q_mem [QDEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [PW:0]      cnt_q;
	logic             push;

	always_comb begin
		new_item.action    = action_t'(action);
		new_item.bin_index = bin_index;
		new_item.det       = detector_id;
		new_item.tval      = time_value;
		new_item.in_window = (frame_time >= window_start) && (frame_time < window_end);
		new_item.det_zero  = (detector_id == '0);
		new_item.det_oob   = (32'(detector_id) >= 32'(DETECTORS));
		new_item.edge_oob  = (32'(bin_index) > 32'(BINS));
		new_item.bin_oob   = (32'(bin_index) >= 32'(BINS));
	end

	assign busy       = (cnt_q == (PW+1)'(QDEPTH)) || clearing;
	assign push       = start && !busy;
	assign head_valid = (cnt_q != '0);
	assign head       = q_mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// File: rtl/etof_back.sv
// ----------------------------------------------------------------------------
// Histogrammer back end
// Executes queued items: edge writes, frames, bin search, count update and count reads.
// ----------------------------------------------------------------------------
`default_nettype none

module etof_back #(
	parameter int unsigned DETECTORS = etof_pkg::DETECTORS_DEF,
	parameter int unsigned BINS      = etof_pkg::BINS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  etof_pkg::item_t             head,
	output logic                        pop,
	output logic                        clearing,
	input  logic [etof_pkg::IDX_W-1:0]  bins_in_use,
	output logic                        done,
	output logic [etof_pkg::CNT_W-1:0]  count_value,
	output logic [etof_pkg::CNT_W-1:0]  frames_binned,
	output logic [etof_pkg::STAT_W-1:0] status
);
	import etof_pkg::*;

	localparam int unsigned EDEPTH = BINS + 1;
	localparam int unsigned EW     = $clog2(EDEPTH);
	localparam int unsigned CDEPTH = DETECTORS * BINS;
	localparam int unsigned CW     = $clog2(CDEPTH);

	back_state_t        state_q, state_n;
	item_t              item_q;
	logic [EW-1:0]      lo_q, hi_q, mid_q;
	logic [CW-1:0]      caddr_q, clr_q;
	logic               fiw_q;
	logic [CNT_W-1:0]   fbc_q, fbc_n;

	logic [31:0]        n32;
	logic [EW-1:0]      n_c;
	logic [EW-1:0]      sel_lo, sel_hi, sel_mid;
	logic               cont, ge, ev_ok, rd_ok;
	logic [31:0]        cbin;
	logic [CW-1:0]      caddr_c;

	logic               e_we;
	logic [EW-1:0]      e_raddr;
	logic [TIME_W-1:0]  e_rdata;
	logic               c_we;
	logic [CW-1:0]      c_waddr;
	logic [CNT_W-1:0]   c_wdata, c_rdata;

	logic               resp;
	status_t            resp_stat;
	logic [CNT_W-1:0]   resp_cnt;

	etof_ram #(.WIDTH(TIME_W), .DEPTH(EDEPTH)) u_edges (
		.clk   (clk),
		.we    (e_we),
		.waddr (item_q.bin_index[EW-1:0]),
		.wdata (item_q.tval),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	etof_ram #(.WIDTH(CNT_W), .DEPTH(CDEPTH)) u_counts (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (caddr_c),
		.rdata (c_rdata)
	);

	// clamp bins in use to [1, BINS]
	always_comb begin
		if (bins_in_use == '0) begin
			n32 = 32'd1;
		end else if (32'(bins_in_use) > 32'(BINS)) begin
			n32 = 32'(BINS);
		end else begin
			n32 = 32'(bins_in_use);
		end
		n_c = n32[EW-1:0];
	end

	// one halving step of the search
	always_comb begin
		ge = (item_q.tval >= e_rdata);
		if (state_q == B_SRCH) begin
			sel_lo = ge ? mid_q : lo_q;
			sel_hi = ge ? hi_q : mid_q;
		end else begin
			sel_lo = '0;
			sel_hi = n_c;
		end
		cont    = ((sel_hi - sel_lo) > EW'(1));
		sel_mid = EW'(({1'b0, sel_lo} + {1'b0, sel_hi}) >> 1);
		cbin    = (state_q == B_DECODE) ? 32'(item_q.bin_index) : 32'(sel_lo);
		caddr_c = CW'(32'(item_q.det) * 32'(BINS) + cbin);
	end

	assign ev_ok = fiw_q && !item_q.det_zero && !item_q.det_oob;
	assign rd_ok = !item_q.det_oob && !item_q.bin_oob;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			B_CLEAR: begin
				if (clr_q == CW'(CDEPTH - 1)) state_n = B_IDLE;
			end
			B_IDLE: begin
				if (head_valid) state_n = B_DECODE;
			end
			B_DECODE: begin
				if (item_q.action == ACT_EVENT && ev_ok) begin
					state_n = B_CHK0;
				end else if (item_q.action == ACT_READ && rd_ok) begin
					state_n = B_CRD;
				end else begin
					state_n = B_IDLE;
				end
			end
			B_CHK0: begin
				state_n = ge ? B_CHKN : B_IDLE;
			end
			B_CHKN: begin
				if (ge) begin
					state_n = B_IDLE;
				end else begin
					state_n = cont ? B_SRCH : B_CINC;
				end
			end
			B_SRCH: begin
				state_n = cont ? B_SRCH : B_CINC;
			end
			B_CINC:  state_n = B_IDLE;
			B_CRD:   state_n = B_IDLE;
			default: state_n = B_IDLE;
		endcase
	end

	// outputs and memory strobes
	always_comb begin
		resp      = 1'b0;
		resp_stat = ST_DONE;
		resp_cnt  = '0;
		e_we      = 1'b0;
		e_raddr   = sel_mid;
		c_we      = 1'b0;
		c_waddr   = caddr_q;
		c_wdata   = sat_inc(c_rdata);
		fbc_n     = fbc_q;
		pop       = (state_q == B_IDLE) && head_valid;
		clearing  = (state_q == B_CLEAR);
		case (state_q)
			B_CLEAR: begin
				c_we    = 1'b1;
				c_waddr = clr_q;
				c_wdata = '0;
			end
			B_DECODE: begin
				e_raddr = '0;
				case (item_q.action)
					ACT_EDGE: begin
						resp      = 1'b1;
						e_we      = !item_q.edge_oob;
						resp_stat = item_q.edge_oob ? ST_IGNORED : ST_DONE;
					end
					ACT_FRAME: begin
						resp      = 1'b1;
						resp_stat = item_q.in_window ? ST_DONE : ST_IGNORED;
						if (item_q.in_window) fbc_n = sat_inc(fbc_q);
					end
					ACT_EVENT: begin
						resp = !ev_ok;
						resp_stat = (!fiw_q || item_q.det_zero) ? ST_IGNORED : ST_DET_RANGE;
					end
					default: begin
						resp      = !rd_ok;
						resp_stat = item_q.det_oob ? ST_DET_RANGE : ST_IGNORED;
					end
				endcase
			end
			B_CHK0: begin
				e_raddr   = n_c;
				resp      = !ge;
				resp_stat = ST_IGNORED;
			end
			B_CHKN: begin
				resp      = ge;
				resp_stat = ST_IGNORED;
			end
			B_CINC: begin
				c_we = 1'b1;
				resp = 1'b1;
			end
			B_CRD: begin
				resp     = 1'b1;
				resp_cnt = c_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		if (state_q == B_CHKN || state_q == B_SRCH) begin
			lo_q  <= sel_lo;
			hi_q  <= sel_hi;
			mid_q <= sel_mid;
		end
		if (state_q != B_CINC) begin
			caddr_q <= caddr_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_CLEAR;
			clr_q         <= '0;
			fiw_q         <= 1'b0;
			fbc_q         <= '0;
			done          <= 1'b0;
			count_value   <= '0;
			frames_binned <= '0;
			status        <= ST_DONE;
		end else begin
			state_q <= state_n;
			done    <= resp;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == B_DECODE && item_q.action == ACT_FRAME) begin
				fiw_q <= item_q.in_window;
			end
			fbc_q <= fbc_n;
			if (resp) begin
				count_value   <= resp_cnt;
				frames_binned <= fbc_n;
				status        <= resp_stat;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/event_tof_histogrammer.sv
// ----------------------------------------------------------------------------
// Event TOF histogrammer, top level
// Usage:
//  - Commands enter on start when busy is low: action selects edge write,
//    frame start, event or count read; the remaining ports carry its fields.
//  - Each command gives exactly one result, shown on count_value,
//    frames_binned and status for one cycle with done high.
//  - Items run one at a time through the back end. Edge, frame and
//    items refused on their fields finish at decode; a count read then
//    reads the count RAM; an event is checked against edge 0 and the
//    edge at bins in use, then placed by a bin search with one edge RAM
//    read per halving step, and its count is updated.
//  - A two-entry queue holds accepted commands; busy rises when it is full.
//  - Configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data;
//    cfg_ready is always high. Write only while no command is in flight.
//  - After reset the count RAM is cleared, one entry per cycle, over all
//    DETECTORS*BINS entries (262144 by default); busy stays high meanwhile.
//  - The receiver cannot stall; results are simply presented.
// ----------------------------------------------------------------------------
`default_nettype none

module event_tof_histogrammer #(
	parameter int unsigned DETECTORS = etof_pkg::DETECTORS_DEF,
	parameter int unsigned BINS      = etof_pkg::BINS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     action,
	input  logic [etof_pkg::IDX_W-1:0]     bin_index,
	input  logic [etof_pkg::DET_W-1:0]     detector_id,
	input  logic [etof_pkg::TIME_W-1:0]    time_value,
	input  logic [etof_pkg::FRAME_W-1:0]   frame_time,
	output logic                           done,
	output logic [etof_pkg::CNT_W-1:0]     count_value,
	output logic [etof_pkg::CNT_W-1:0]     frames_binned,
	output logic [etof_pkg::STAT_W-1:0]    status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [etof_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [etof_pkg::FRAME_W-1:0]   cfg_data
);
	import etof_pkg::*;

	logic [FRAME_W-1:0] win_start_q, win_end_q;
	logic [IDX_W-1:0]   bins_q;
	logic               clearing, pop, head_valid;
	item_t              head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= '0;
			win_end_q   <= WIN_END_RST;
			bins_q      <= BINS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_WIN_START: win_start_q <= cfg_data;
				CFG_WIN_END:   win_end_q   <= cfg_data;
				CFG_BINS:      bins_q      <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	etof_front #(.DETECTORS(DETECTORS), .BINS(BINS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.bin_index    (bin_index),
		.detector_id  (detector_id),
		.time_value   (time_value),
		.frame_time   (frame_time),
		.window_start (win_start_q),
		.window_end   (win_end_q),
		.clearing     (clearing),
		.pop          (pop),
		.head_valid   (head_valid),
		.head         (head)
	);

	etof_back #(.DETECTORS(DETECTORS), .BINS(BINS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.clearing      (clearing),
		.bins_in_use   (bins_q),
		.done          (done),
		.count_value   (count_value),
		.frames_binned (frames_binned),
		.status        (status)
	);

endmodule

`default_nettype wire

// File: rtl/etof_checker.sv
// ----------------------------------------------------------------------------
// Histogrammer port checker
// Watches the result ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "event_tof_histogrammer_defines.svh"

module etof_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        done,
	input logic [etof_pkg::CNT_W-1:0]  count_value,
	input logic [etof_pkg::CNT_W-1:0]  frames_binned,
	input logic [etof_pkg::STAT_W-1:0] status
);
	import etof_pkg::*;

	`ETOF_ASSERT_NOW(a_refused_zero, done && (status != ST_DONE), count_value == '0, "refused item returned a count")
	`ETOF_ASSERT_NEXT(a_single_strobe, done, !done, "results on two adjacent cycles")
	`ETOF_ASSERT_NOW(a_frames_hold, !done, $stable(frames_binned), "frame count moved without a result")

endmodule

bind event_tof_histogrammer etof_checker u_chk (.*);

`default_nettype wire
